// File: sv/word_to_ascii_radix_formatter_core_macros.svh
// Assertion macros for the word-to-ASCII formatter core.
`ifndef WORD_TO_ASCII_RADIX_FORMATTER_CORE_MACROS_SVH
`define WORD_TO_ASCII_RADIX_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define W2A_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define W2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/w2a_pkg.sv
// Shared constants and helper functions for the word-to-ASCII formatter.
package w2a_pkg;

  // Word geometry
  localparam int WORD_BITS  = 32;
  localparam int CNT_W      = $clog2(WORD_BITS + 1);
  // Decimal digits needed for the largest word: floor(bits * log10(2)) + 1
  localparam int DEC_DIGITS = (WORD_BITS * 1233) / 4096 + 1;
  localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;
  localparam int OCT_DIGITS = (WORD_BITS + 2) / 3;
  localparam int OCT_PAD    = OCT_DIGITS * 3 - WORD_BITS;
  localparam int DIG_BITS   = 4 * DEC_DIGITS;

  // Format selector codes
  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_HEX  = 3'd2;
  localparam logic [2:0] OP_OCT  = 3'd3;
  localparam logic [2:0] OP_BIN  = 3'd4;

  // Characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_NL    = 8'h0a;

  typedef logic [WORD_BITS-1:0] word_t;

  // Reverse the whole low bytes; leftover high bits stay in place
  function automatic word_t byte_swap(input word_t v);
    word_t r;
    r = v;
    for (int k = 0; k < WORD_BITS / 8; k++) begin
      r[(WORD_BITS / 8 - 1 - k) * 8 +: 8] = v[k * 8 +: 8];
    end
    return r;
  endfunction

  // Digit value to lower-case ASCII
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = CH_ZERO + {4'd0, d};
    else           c = CH_A + {4'd0, d} - 8'd10;
    return c;
  endfunction

endpackage

// File: sv/word_to_ascii_radix_formatter_core.sv
// Word-to-ASCII radix formatter core: one word in, its text out a character at a time.
//
// Input channel (in_value, in_op, in_swap): a transfer happens when in_valid is
// high and in_stall low. in_stall stays high from the transfer until the
// newline of that item has been loaded into the output register.
// in_op selects signed decimal, unsigned decimal, "0x" hex, "0o" octal or
// "0b" binary; in_swap reverses the byte order of the word first.
// Output channel (out_text_char, out_last): one character per transfer, leading
// zeros suppressed, at least one digit, newline last with out_last high.
// Unused selector codes give only the newline.
// Sequence: decimal formats first run the shift-and-add-3 converter, one input
// bit per cycle, then scan the 10 BCD digits. Digit positions (10, 8, 11 or 32)
// are scanned one per cycle, emitted or suppressed, after any prefix characters
// and before the newline; a shown digit waits while the output stalls. The next
// input transfer can follow once the newline is loaded. A single digit shift
// register serves every format and one BCD adjust unit the decimal conversion.
// Output stalls hold the sequencer whenever it has a character to load; nothing
// is dropped.
// Reset (rst_n low, synchronous) returns to idle and clears the output valid.
`include "word_to_ascii_radix_formatter_core_macros.svh"

module word_to_ascii_radix_formatter_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [w2a_pkg::WORD_BITS-1:0] in_value,
  input  logic [2:0]                 in_op,
  input  logic                       in_swap,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_text_char,
  output logic                       out_last
);
  import w2a_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_PFX0 = 3'd2;
  localparam logic [2:0] S_PFX1 = 3'd3;
  localparam logic [2:0] S_DIG  = 3'd4;
  localparam logic [2:0] S_NL   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [2:0]          op_r, op_nxt;
  logic                neg_r, neg_nxt;
  logic                seen_r, seen_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  word_t               bin_r, bin_nxt;
  logic [DIG_BITS-1:0] dig_r, dig_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  word_t               in_word;
  logic [DIG_BITS-1:0] bcd_adj;
  logic [DIG_BITS-1:0] dig_shift;
  logic [3:0]          top_dig;
  logic                is_dec;
  logic                slot_free;
  logic                dig_show;
  logic [7:0]          tag_char;

  assign in_word   = in_swap ? byte_swap(in_value) : in_value;
  assign is_dec    = (op_r == OP_SDEC) || (op_r == OP_UDEC);
  assign slot_free = !out_valid_r || !out_stall;

  // BCD add-3 adjust on every digit lane
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (dig_r[4 * i +: 4] >= 4'd5) bcd_adj[4 * i +: 4] = dig_r[4 * i +: 4] + 4'd3;
      else                           bcd_adj[4 * i +: 4] = dig_r[4 * i +: 4];
    end
  end

  // Top digit and shift by the digit width of the format
  always_comb begin
    case (op_r)
      OP_OCT: begin
        top_dig   = {1'b0, dig_r[DIG_BITS-1 -: 3]};
        dig_shift = dig_r << 3;
      end
      OP_BIN: begin
        top_dig   = {3'd0, dig_r[DIG_BITS-1]};
        dig_shift = dig_r << 1;
      end
      default: begin
        top_dig   = dig_r[DIG_BITS-1 -: 4];
        dig_shift = dig_r << 4;
      end
    endcase
  end

  assign dig_show = (top_dig != 4'd0) || seen_r || (cnt_r == CNT_W'(1));

  // Radix tag character
  always_comb begin
    case (op_r)
      OP_HEX:  tag_char = CH_X;
      OP_OCT:  tag_char = CH_O;
      default: tag_char = CH_B;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    neg_nxt       = neg_r;
    seen_nxt      = seen_r;
    cnt_nxt       = cnt_r;
    bin_nxt       = bin_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_op;
          neg_nxt  = (in_op == OP_SDEC) && in_word[WORD_BITS-1];
          seen_nxt = 1'b0;
          case (in_op)
            OP_SDEC, OP_UDEC: begin
              bin_nxt   = ((in_op == OP_SDEC) && in_word[WORD_BITS-1]) ?
                          (~in_word + word_t'(1)) : in_word;
              dig_nxt   = '0;
              cnt_nxt   = CNT_W'(WORD_BITS);
              state_nxt = S_CONV;
            end
            OP_HEX: begin
              dig_nxt   = DIG_BITS'(in_word) << (DIG_BITS - 4 * HEX_DIGITS);
              cnt_nxt   = CNT_W'(HEX_DIGITS);
              state_nxt = S_PFX0;
            end
            OP_OCT: begin
              dig_nxt   = DIG_BITS'(in_word) << (DIG_BITS - WORD_BITS - OCT_PAD);
              cnt_nxt   = CNT_W'(OCT_DIGITS);
              state_nxt = S_PFX0;
            end
            OP_BIN: begin
              dig_nxt   = DIG_BITS'(in_word) << (DIG_BITS - WORD_BITS);
              cnt_nxt   = CNT_W'(WORD_BITS);
              state_nxt = S_PFX0;
            end
            default: state_nxt = S_NL;
          endcase
        end
      end

      // Shift-and-add-3: one magnitude bit into the BCD register per cycle
      S_CONV: begin
        dig_nxt = {bcd_adj[DIG_BITS-2:0], bin_r[WORD_BITS-1]};
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          cnt_nxt   = CNT_W'(DEC_DIGITS);
          state_nxt = neg_r ? S_PFX0 : S_DIG;
        end
      end

      // '-' for negative decimal, else the leading '0' of a radix prefix
      S_PFX0: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = is_dec ? CH_MINUS : CH_ZERO;
          out_last_nxt  = 1'b0;
          state_nxt     = is_dec ? S_DIG : S_PFX1;
        end
      end

      S_PFX1: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = tag_char;
          out_last_nxt  = 1'b0;
          state_nxt     = S_DIG;
        end
      end

      // One digit position per cycle, leading zeros skipped; a shown digit waits while the output stalls
      S_DIG: begin
        if (slot_free || !dig_show) begin
          if (dig_show) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = digit_char(top_dig);
            out_last_nxt  = 1'b0;
            seen_nxt      = 1'b1;
          end
          dig_nxt = dig_shift;
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) state_nxt = S_NL;
        end
      end

      S_NL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_NL;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    neg_r      <= neg_nxt;
    seen_r     <= seen_nxt;
    cnt_r      <= cnt_nxt;
    bin_r      <= bin_nxt;
    dig_r      <= dig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last      = out_last_r;

  // Checks
  `W2A_ASSERT_NEXT(a_busy_after_xfer, in_valid && !in_stall, state_r != S_IDLE,
    "sequencer did not leave idle after an input transfer")
  `W2A_ASSERT_IMPL(a_cnt_live, (state_r == S_CONV) || (state_r == S_DIG), cnt_r != '0,
    "digit counter ran out while converting or scanning")
  `W2A_ASSERT_IMPL(a_last_digit_shown, ($past(state_r) == S_DIG) && (state_r == S_NL),
    seen_r, "no digit emitted before the newline")
endmodule
